[design/positional_sequence_buffer_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the positional sequence buffer
// Property checks that disappear from synthesis builds.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_SEQUENCE_BUFFER_DEFINES_SVH
`define POSITIONAL_SEQUENCE_BUFFER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked property, switched off while reset is held.
`define PSB_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked property that also holds during reset.
`define PSB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSB_ASSERT(lbl, clk, rstn, prop, msg)
`define PSB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[design/psb_pkg.sv]
// ----------------------------------------------------------------------------
// psb_pkg
// Types and constants shared by the positional sequence buffer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psb_pkg;

    localparam int PSB_CAPACITY = 64;
    localparam int DATA_W       = 32;
    localparam int OP_W         = 3;
    localparam int ST_W         = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_INSERT     = 3'd4,
        OP_ERASE      = 3'd5,
        OP_CLEAR      = 3'd6,
        OP_QUERY      = 3'd7
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    // Broadcast to every cell of a chain for one item.
    typedef struct packed {
        logic              ins;
        logic              era;
        logic [DATA_W-1:0] value;
    } psb_ctl_t;

endpackage

[design/psb_cell.sv]
// ----------------------------------------------------------------------------
// psb_cell
// One storage place of a chain: holds, loads the new value, or takes the
// word of its left or right neighbour.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psb_cell
    import psb_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic              aclk,
    input  psb_ctl_t          ctl,
    input  logic [CNT_W-1:0]  pos,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    output logic [DATA_W-1:0] data
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctl.ins) begin
            if (MY_IDX > pos) begin
                data_next = left_data;
            end else if (MY_IDX == pos) begin
                data_next = ctl.value;
            end
        end else if (ctl.era) begin
            if (MY_IDX >= pos) begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[design/psb_chain.sv]
// ----------------------------------------------------------------------------
// psb_chain
// A row of cells that opens a gap or closes one at a given index, all cells
// moving on the same clock edge. The head of the row is the first element.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psb_chain
    import psb_pkg::*;
#(
    parameter int CAPACITY = PSB_CAPACITY,
    parameter int CNT_W    = $clog2(PSB_CAPACITY + 1)
) (
    input  logic              aclk,
    input  psb_ctl_t          ctl,
    input  logic [CNT_W-1:0]  pos,
    output logic [DATA_W-1:0] head
);

    logic [DATA_W-1:0] cell_data [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] right_w;

        // The ends feed back their own word; the first cell never takes it.
        if (i == 0) begin : g_first
            assign left_w = cell_data[i];
        end else begin : g_left
            assign left_w = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_w = cell_data[i];
        end else begin : g_right
            assign right_w = cell_data[i+1];
        end

        psb_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .pos        (pos),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[i])
        );
    end

    assign head = cell_data[0];

endmodule

[design/positional_sequence_buffer.sv]
// ----------------------------------------------------------------------------
// positional_sequence_buffer
// Bounded deque of signed 32-bit words with insert and erase at any index.
// ----------------------------------------------------------------------------
// The sequence is kept twice, in two chains of CAPACITY cells: one in order
// from the front and one in reverse from the back, so the front and back
// values are always the heads of the chains. Every push, pop, insert and
// erase is turned into an insert or erase at one index of each chain, and all
// cells shift in the same clock edge, so a new item is taken every cycle
// while the result register is empty or being read. Each item gives one
// result that describes the sequence after it. The cells need no clearing
// after reset; only the element count and the result valid flag are reset.
`timescale 1ns / 1ps

`include "positional_sequence_buffer_defines.svh"

module positional_sequence_buffer
    import psb_pkg::*;
#(
    parameter int CAPACITY = PSB_CAPACITY,
    localparam int CNT_W   = $clog2(CAPACITY + 1),
    localparam int S_W     = ((OP_W + CNT_W + DATA_W + 7) / 8) * 8,
    localparam int M_W     = ((ST_W + 2 * DATA_W + CNT_W + 1 + 7) / 8) * 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    // operation, position, value
    input  logic [S_W-1:0] s_tdata,
    output logic           m_tvalid,
    input  logic           m_tready,
    // status, front_value, back_value, count_now, is_empty
    output logic [M_W-1:0] m_tdata
);

    localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

    logic [OP_W-1:0]   s_op;
    logic [CNT_W-1:0]  s_pos;
    logic [DATA_W-1:0] s_value;

    assign s_op    = s_tdata[OP_W-1:0];
    assign s_pos   = s_tdata[OP_W +: CNT_W];
    assign s_value = s_tdata[OP_W+CNT_W +: DATA_W];

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    status_t          status_reg;
    status_t          status_next;

    logic             accept;
    logic             full;
    logic             empty;
    logic             do_ins;
    logic             do_era;
    logic [CNT_W-1:0] pos_a;
    logic [CNT_W-1:0] pos_b;
    psb_ctl_t         ctl_a;
    psb_ctl_t         ctl_b;
    logic [DATA_W-1:0] head_a;
    logic [DATA_W-1:0] head_b;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg >= CAP);
    assign empty    = (count_reg == '0);

    // Status, next count, and the index in the forward chain (pos_a) and in the reversed chain (pos_b).
    always_comb begin
        status_next = ST_DONE;
        do_ins      = 1'b0;
        do_era      = 1'b0;
        pos_a       = '0;
        pos_b       = '0;
        count_next  = count_reg;
        case (op_t'(s_op))
            OP_PUSH_FRONT: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                    pos_b  = count_reg;
                end
            end
            OP_PUSH_BACK: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                    pos_a  = count_reg;
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    status_next = ST_IGNORED;
                end else begin
                    do_era = 1'b1;
                    pos_b  = count_reg - ONE;
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    status_next = ST_IGNORED;
                end else begin
                    do_era = 1'b1;
                    pos_a  = count_reg - ONE;
                end
            end
            OP_INSERT: begin
                if (s_pos > count_reg) begin
                    status_next = ST_IGNORED;
                end else if (full) begin
                    status_next = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                    pos_a  = s_pos;
                    pos_b  = count_reg - s_pos;
                end
            end
            OP_ERASE: begin
                if (s_pos >= count_reg) begin
                    status_next = ST_IGNORED;
                end else begin
                    do_era = 1'b1;
                    pos_a  = s_pos;
                    pos_b  = count_reg - ONE - s_pos;
                end
            end
            OP_CLEAR: begin
                count_next = '0;
            end
            default: begin
            end
        endcase
        if (do_ins) begin
            count_next = count_reg + ONE;
        end else if (do_era) begin
            count_next = count_reg - ONE;
        end
    end

    assign ctl_a = '{ins: accept && do_ins, era: accept && do_era, value: s_value};
    assign ctl_b = ctl_a;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
        end
    end

    psb_chain #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_fwd (
        .aclk (aclk),
        .ctl  (ctl_a),
        .pos  (pos_a),
        .head (head_a)
    );

    psb_chain #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_rev (
        .aclk (aclk),
        .ctl  (ctl_b),
        .pos  (pos_b),
        .head (head_b)
    );

    // The cells only move on an accepted item, which also reloads the
    // result register, so the heads always match the waiting result.
    logic [DATA_W-1:0] front_w;
    logic [DATA_W-1:0] back_w;

    assign front_w  = empty ? '1 : head_a;
    assign back_w   = empty ? '1 : head_b;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_W'({empty, count_reg, back_w, front_w, status_reg});

    `PSB_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CAP, "count above capacity")
    `PSB_ASSERT(a_push_front_head, aclk, aresetn,
        accept && op_t'(s_op) == OP_PUSH_FRONT && !full |=> head_a == $past(s_value),
        "front does not hold the pushed value")
    `PSB_ASSERT(a_push_back_head, aclk, aresetn,
        accept && op_t'(s_op) == OP_PUSH_BACK && !full |=> head_b == $past(s_value),
        "back does not hold the pushed value")
    `PSB_ASSERT(a_single_elem, aclk, aresetn,
        m_valid_reg && count_reg == ONE |-> head_a == head_b,
        "front and back differ with one element")

endmodule

[dv/positional_sequence_buffer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_sequence_buffer_tb
// Self-checking bench for the bounded deque with positional insert and erase.
// Directed corner cases come first. Random command streams follow, and they
// fill the sequence to capacity and drain it again. A scoreboard compares
// every result with a queue-based prediction of the stored sequence. Both
// stream sides idle at random, and the receiver also holds off for a long
// stretch.
// ----------------------------------------------------------------------------
module positional_sequence_buffer_tb;
    import psb_pkg::*;

    localparam int CNT_W       = $clog2(PSB_CAPACITY + 1);
    localparam int IN_W        = ((OP_W + CNT_W + DATA_W + 7) / 8) * 8;
    localparam int OUT_W       = ((ST_W + 2 * DATA_W + CNT_W + 1 + 7) / 8) * 8;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    // Packed so that the last field sits in the lowest bits of tdata.
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [CNT_W-1:0]  pos;
        op_t               op;
    } deque_cmd_t;

    typedef struct packed {
        logic              is_empty;
        logic [CNT_W-1:0]  count_now;
        logic [DATA_W-1:0] back_value;
        logic [DATA_W-1:0] front_value;
        logic [ST_W-1:0]   status;
    } deque_view_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    logic [DATA_W-1:0] model_seq[$];
    deque_view_t       pending_views[$];

    bit tx_idle_on    = 1'b1;
    bit rx_idle_on    = 1'b1;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int failures      = 0;
    int results_seen  = 0;
    int items_sent    = 0;
    int full_rejects  = 0;
    int ignored_items = 0;
    int peak_depth    = 0;
    int op_tally[8];

    positional_sequence_buffer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Applies one command to the predicted sequence and returns the view after it.
    function automatic deque_view_t apply_cmd(deque_cmd_t c);
        deque_view_t v;
        int depth;
        depth = model_seq.size();
        v.status = ST_DONE;
        case (c.op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (depth >= PSB_CAPACITY) v.status = ST_FULL;
                else if (c.op == OP_PUSH_FRONT) model_seq.push_front(c.value);
                else model_seq.push_back(c.value);
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (depth == 0) v.status = ST_IGNORED;
                else if (c.op == OP_POP_FRONT) void'(model_seq.pop_front());
                else void'(model_seq.pop_back());
            end
            OP_INSERT: begin
                // The position is checked before fullness.
                if (int'(c.pos) > depth) v.status = ST_IGNORED;
                else if (depth >= PSB_CAPACITY) v.status = ST_FULL;
                else model_seq.insert(int'(c.pos), c.value);
            end
            OP_ERASE: begin
                if (int'(c.pos) >= depth) v.status = ST_IGNORED;
                else model_seq.delete(int'(c.pos));
            end
            OP_CLEAR: model_seq.delete();
            default: ;
        endcase
        depth = model_seq.size();
        v.front_value = (depth == 0) ? '1 : model_seq[0];
        v.back_value  = (depth == 0) ? '1 : model_seq[depth - 1];
        v.count_now   = CNT_W'(depth);
        v.is_empty    = (depth == 0);
        return v;
    endfunction

    function automatic deque_cmd_t make_cmd(op_t op, int pos, logic [DATA_W-1:0] value);
        deque_cmd_t c;
        c.op    = op;
        c.pos   = CNT_W'(pos);
        c.value = value;
        return c;
    endfunction

    function automatic logic [DATA_W-1:0] random_value();
        case ($urandom_range(0, 7))
            0: return {1'b1, {(DATA_W - 1){1'b0}}};
            1: return {1'b0, {(DATA_W - 1){1'b1}}};
            2: return '1;
            3: return '0;
            default: return $urandom();
        endcase
    endfunction

    // Mostly well-formed commands aimed at the current depth; grow_pct steers
    // the balance between growing and shrinking the sequence.
    function automatic deque_cmd_t random_cmd(int grow_pct, bit allow_clear);
        deque_cmd_t c;
        int depth;
        int roll;
        depth   = model_seq.size();
        c.value = random_value();
        c.pos   = '0;
        roll    = $urandom_range(0, 99);
        if (allow_clear && roll < 2) begin
            c.op = OP_CLEAR;
        end else if (roll < 8) begin
            c.op = OP_QUERY;
        end else if ($urandom_range(0, 99) < grow_pct) begin
            case ($urandom_range(0, 2))
                0: c.op = OP_PUSH_FRONT;
                1: c.op = OP_PUSH_BACK;
                default: begin
                    c.op  = OP_INSERT;
                    c.pos = CNT_W'($urandom_range(0, depth));
                end
            endcase
        end else begin
            case ($urandom_range(0, 2))
                0: c.op = OP_POP_FRONT;
                1: c.op = OP_POP_BACK;
                default: begin
                    c.op  = OP_ERASE;
                    c.pos = (depth == 0) ? '0 : CNT_W'($urandom_range(0, depth - 1));
                end
            endcase
        end
        // Now and then the index is anything the field can hold.
        if ($urandom_range(0, 9) == 0) c.pos = CNT_W'($urandom_range(0, (1 << CNT_W) - 1));
        return c;
    endfunction

    task automatic send_item(input deque_cmd_t cmd);
        deque_view_t view;
        if (tx_idle_on && $urandom_range(0, 99) < 20) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < 20);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'(cmd);
        do @(posedge aclk); while (!s_tready);
        view = apply_cmd(cmd);
        pending_views.push_back(view);
        items_sent++;
        op_tally[int'(cmd.op)]++;
        if (view.status == ST_FULL) full_rejects++;
        if (view.status == ST_IGNORED) ignored_items++;
        if (int'(view.count_now) > peak_depth) peak_depth = int'(view.count_now);
    endtask

    // Waits on the clock before it first checks the scoreboard, so tvalid is never driven twice in a step.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_views.size() != 0);
    endtask

    task automatic test_directed_cases();
        send_item(make_cmd(OP_QUERY, 0, '0));
        send_item(make_cmd(OP_POP_FRONT, 0, '0));
        send_item(make_cmd(OP_POP_BACK, 0, '0));
        send_item(make_cmd(OP_ERASE, 0, '0));
        send_item(make_cmd(OP_INSERT, 1, 32'h1234_5678));
        send_item(make_cmd(OP_INSERT, 0, 32'h7FFF_FFFF));
        send_item(make_cmd(OP_PUSH_FRONT, 0, 32'h8000_0000));
        // A stored -1 must not be mistaken for an empty sequence.
        send_item(make_cmd(OP_PUSH_BACK, 0, 32'hFFFF_FFFF));
        send_item(make_cmd(OP_PUSH_BACK, 127, 32'h0000_0000));
        send_item(make_cmd(OP_INSERT, 4, 32'h5555_5555));
        send_item(make_cmd(OP_INSERT, 1, 32'hAAAA_AAAA));
        send_item(make_cmd(OP_INSERT, 127, 32'h0000_0001));
        send_item(make_cmd(OP_ERASE, 127, '0));
        send_item(make_cmd(OP_ERASE, 6, '0));
        send_item(make_cmd(OP_ERASE, 2, '0));
        send_item(make_cmd(OP_ERASE, 0, '0));
        send_item(make_cmd(OP_POP_FRONT, 0, '0));
        send_item(make_cmd(OP_POP_BACK, 0, '0));
        send_item(make_cmd(OP_QUERY, 0, '0));
        send_item(make_cmd(OP_CLEAR, 0, '0));
        send_item(make_cmd(OP_QUERY, 0, '0));
        send_item(make_cmd(OP_CLEAR, 0, '0));
    endtask

    task automatic test_fill_to_capacity();
        while (model_seq.size() < PSB_CAPACITY) send_item(random_cmd(85, 1'b0));
        send_item(make_cmd(OP_PUSH_FRONT, 0, random_value()));
        send_item(make_cmd(OP_PUSH_BACK, 0, random_value()));
        send_item(make_cmd(OP_INSERT, 10, random_value()));
        send_item(make_cmd(OP_INSERT, PSB_CAPACITY, random_value()));
        send_item(make_cmd(OP_INSERT, PSB_CAPACITY + 1, random_value()));
        send_item(make_cmd(OP_ERASE, PSB_CAPACITY, '0));
        send_item(make_cmd(OP_QUERY, 0, '0));
        send_item(make_cmd(OP_ERASE, PSB_CAPACITY - 1, '0));
        send_item(make_cmd(OP_PUSH_FRONT, 0, random_value()));
        // Sender pauses here until the scoreboard is empty.
        wait_drained();
        while (model_seq.size() != 0) send_item(random_cmd(10, 1'b0));
    endtask

    task automatic test_receiver_hold();
        tx_idle_on = 1'b0;
        hold_requests++;
        repeat (40) send_item(random_cmd(60, 1'b1));
        tx_idle_on = 1'b1;
        wait_drained();
    endtask

    task automatic test_back_to_back();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (150) send_item(random_cmd(55, 1'b1));
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_random_walk();
        repeat (140) send_item(random_cmd(75, 1'b1));
        repeat (140) send_item(random_cmd(50, 1'b1));
        repeat (140) send_item(random_cmd(25, 1'b1));
        repeat (140) send_item(random_cmd(60, 1'b1));
    endtask

    // Result side: random stalls, plus a long hold whenever a test asks for one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            m_tready     <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            holds_served <= hold_requests;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= !(rx_idle_on && $urandom_range(0, 99) < 20);
        end
    end

    always @(posedge aclk) begin
        deque_view_t seen;
        deque_view_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen = m_tdata[$bits(deque_view_t)-1:0];
            results_seen++;
            if (pending_views.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("result %0d arrived with nothing predicted: %h", results_seen,
                             m_tdata);
            end else begin
                want = pending_views.pop_front();
                if (seen.status !== want.status || seen.front_value !== want.front_value ||
                    seen.back_value !== want.back_value ||
                    seen.count_now !== want.count_now || seen.is_empty !== want.is_empty) begin
                    failures++;
                    if (failures <= MAX_REPORTS) begin
                        $display("result %0d: expected status %0d front %h back %h count %0d empty %0b",
                                 results_seen, want.status, want.front_value, want.back_value,
                                 want.count_now, want.is_empty);
                        $display("result %0d:   actual status %0d front %h back %h count %0d empty %0b",
                                 results_seen, seen.status, seen.front_value, seen.back_value,
                                 seen.count_now, seen.is_empty);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("no item moved for %0d cycles, %0d results outstanding", quiet_cycles,
                     pending_views.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_fill_to_capacity();
        test_receiver_hold();
        test_back_to_back();
        test_random_walk();
        wait_drained();
        repeat (8) @(posedge aclk);
        if (pending_views.size() != 0) begin
            failures += pending_views.size();
            $display("%0d predicted results never arrived", pending_views.size());
        end
        $display("%0d items: push front %0d, push back %0d, pop front %0d, pop back %0d, insert %0d, erase %0d, clear %0d, query %0d",
                 items_sent, op_tally[OP_PUSH_FRONT], op_tally[OP_PUSH_BACK],
                 op_tally[OP_POP_FRONT], op_tally[OP_POP_BACK], op_tally[OP_INSERT],
                 op_tally[OP_ERASE], op_tally[OP_CLEAR], op_tally[OP_QUERY]);
        $display("%0d refused when full, %0d ignored, deepest sequence %0d of %0d, %0d failures",
                 full_rejects, ignored_items, peak_depth, PSB_CAPACITY, failures);
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/psb_pkg.sv
design/psb_cell.sv
design/psb_chain.sv
design/positional_sequence_buffer.sv
dv/positional_sequence_buffer_tb.sv
